>>> sv/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg - shared constants of the linked list block
// Default sizes, command codes and result status codes.
// ----------------------------------------------------------------------------
package dll_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int CMD_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_FIRST      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LAST       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PREV       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PUSH_AFTER = 4'd6;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_POP_CURSOR = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

>>> sv/dll_ifs.sv
// ----------------------------------------------------------------------------
// dll_ifs - command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dll_cmd_if #(
    parameter int WORD_WIDTH = dll_pkg::WORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [dll_pkg::CMD_W-1:0]     command;
    logic [WORD_WIDTH-1:0]         data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface dll_res_if #(
    parameter int WORD_WIDTH = dll_pkg::WORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [WORD_WIDTH-1:0]         data_out;
    logic                          has_data;
    logic [dll_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output data_out, output has_data, output status,
                    input ready);
    modport sink   (input valid, input data_out, input has_data, input status,
                    output ready);
endinterface

>>> sv/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dll_ram #(
    parameter  int WIDTH = dll_pkg::WORD_WIDTH_DEF,
    parameter  int DEPTH = dll_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> sv/dll_out_stage.sv
// ----------------------------------------------------------------------------
// dll_out_stage - result output register
// Holds one finished result until the sink takes the beat.
// ----------------------------------------------------------------------------
module dll_out_stage #(
    parameter int WORD_WIDTH = dll_pkg::WORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [WORD_WIDTH-1:0]        i_word,
    input  logic                         i_has,
    input  logic [dll_pkg::STATUS_W-1:0] i_status,
    output logic                         o_free,
    dll_res_if.source                    o_res
);
    import dll_pkg::*;

    logic                r_valid;
    logic [WORD_WIDTH-1:0] r_word;
    logic                r_has;
    logic [STATUS_W-1:0] r_status;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_word   <= i_word;
            r_has    <= i_has;
            r_status <= i_status;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.data_out = r_word;
    assign o_res.has_data = r_has;
    assign o_res.status   = r_status;
endmodule

>>> sv/doubly_linked_list_with_cursor.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_with_cursor - linked list of words with a cursor
// Node pool in three RAMs (word, next link, prev link) run by a sequencer.
// ----------------------------------------------------------------------------
// One command is taken at a time and each gives one result beat. On the way
// to the output register, commands that fail at once or change no node go
// straight to the done state, first/last read the word, next/prev a link and
// then the word, and pops read the node, unlink it and free it. Pushes take
// a node from the free list or the fresh range, read the successor link when
// inserting after a node, then write the new node and its neighbours. The
// node RAMs have registered reads and one write port each, so dependent link
// reads follow one another and the two link updates of one RAM are made in
// turn. The input is ready again in the cycle after the result enters the
// output register, which the sink may hold while the next command runs. The
// node RAMs have no reset; only live nodes are read, so no clearing pass runs
// after reset or on clear.
module doubly_linked_list_with_cursor #(
    parameter int DEPTH      = dll_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = dll_pkg::WORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dll_cmd_if.sink   i_cmd,
    dll_res_if.source o_res
);
    import dll_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LINK  = 9'b000000010,
        S_WORD  = 9'b000000100,
        S_FREE  = 9'b000001000,
        S_AFTER = 9'b000010000,
        S_WR1   = 9'b000100000,
        S_WR2   = 9'b001000000,
        S_POP   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    function automatic logic f_live(input logic [PW-1:0] p);
        return p < NIL;
    endfunction

    t_state r_state, n_state;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [WORD_WIDTH-1:0] r_data, n_data;
    logic [PW-1:0]         r_node, n_node;
    logic [PW-1:0]         r_aux, n_aux;
    logic [PW-1:0]         r_after, n_after;
    logic                  r_ins, n_ins;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_tail, n_tail;
    logic [PW-1:0]         r_cursor, n_cursor;
    logic [PW-1:0]         r_free, n_free;
    logic [PW-1:0]         r_fresh, n_fresh;
    logic [WORD_WIDTH-1:0] r_res_word, n_res_word;
    logic                  r_res_has, n_res_has;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;

    logic                  word_we, word_re, next_we, next_re, prev_we, prev_re;
    logic [AW-1:0]         word_wa, word_ra, next_wa, next_ra, prev_wa, prev_ra;
    logic [WORD_WIDTH-1:0] word_wd, word_rd;
    logic [PW-1:0]         next_wd, next_rd, prev_wd, prev_rd;
    logic                  out_free;

    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        logic [PW-1:0] tgt;
        logic [PW-1:0] c;
        logic          ins;
        tgt = NIL;
        c   = NIL;
        ins = 1'b0;

        n_state      = r_state;
        n_cmd        = r_cmd;
        n_data       = r_data;
        n_node       = r_node;
        n_aux        = r_aux;
        n_after      = r_after;
        n_ins        = r_ins;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cursor     = r_cursor;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_res_word   = r_res_word;
        n_res_has    = r_res_has;
        n_res_status = r_res_status;

        word_we = 1'b0; word_wa = '0; word_wd = '0; word_re = 1'b0; word_ra = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0; next_re = 1'b0; next_ra = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_re = 1'b0; prev_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd        = i_cmd.command;
                    n_data       = i_cmd.data_in;
                    n_ins        = 1'b0;
                    n_res_word   = '0;
                    n_res_has    = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    unique case (i_cmd.command)
                        CMD_FIRST, CMD_LAST: begin
                            tgt = (i_cmd.command == CMD_FIRST) ? r_head : r_tail;
                            if (f_live(tgt)) begin
                                word_re  = 1'b1;
                                word_ra  = tgt[AW-1:0];
                                n_cursor = tgt;
                                n_state  = S_WORD;
                            end else begin
                                n_res_status = ST_NO_NODE;
                            end
                        end
                        CMD_NEXT, CMD_PREV: begin
                            if (f_live(r_cursor)) begin
                                next_re = (i_cmd.command == CMD_NEXT);
                                next_ra = r_cursor[AW-1:0];
                                prev_re = (i_cmd.command == CMD_PREV);
                                prev_ra = r_cursor[AW-1:0];
                                n_state = S_LINK;
                            end else begin
                                n_res_status = ST_NO_NODE;
                            end
                        end
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_AFTER: begin
                            // c is the node to insert after; for push front
                            // the old head is kept instead
                            priority if (i_cmd.command == CMD_PUSH_FRONT) begin
                                c = r_head;
                            end else if (i_cmd.command == CMD_PUSH_BACK) begin
                                c        = r_tail;
                                n_cursor = r_tail;
                                ins      = f_live(r_tail);
                            end else begin
                                c   = r_cursor;
                                ins = 1'b1;
                            end
                            n_aux = c;
                            n_ins = ins;
                            priority if (i_cmd.command == CMD_PUSH_AFTER && !f_live(r_cursor))
                            begin
                                n_res_status = ST_NO_NODE;
                            end else if (f_live(r_free)) begin
                                next_re = 1'b1;
                                next_ra = r_free[AW-1:0];
                                n_node  = r_free;
                                n_state = S_FREE;
                            end else if (r_fresh < NIL) begin
                                n_node  = r_fresh;
                                n_fresh = r_fresh + PW'(1);
                                if (ins) begin
                                    next_re = 1'b1;
                                    next_ra = c[AW-1:0];
                                    n_state = S_AFTER;
                                end else begin
                                    n_state = S_WR1;
                                end
                            end else begin
                                n_res_status = ST_FULL;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURSOR: begin
                            priority if (i_cmd.command == CMD_POP_FRONT) begin
                                tgt = r_head;
                            end else if (i_cmd.command == CMD_POP_BACK) begin
                                tgt = r_tail;
                            end else begin
                                tgt = r_cursor;
                            end
                            n_cursor = tgt;
                            if (f_live(tgt)) begin
                                word_re = 1'b1;
                                word_ra = tgt[AW-1:0];
                                next_re = 1'b1;
                                next_ra = tgt[AW-1:0];
                                prev_re = 1'b1;
                                prev_ra = tgt[AW-1:0];
                                n_node  = tgt;
                                n_state = S_POP;
                            end else begin
                                n_res_status = ST_NO_NODE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_head   = NIL;
                            n_tail   = NIL;
                            n_cursor = NIL;
                            n_free   = NIL;
                            n_fresh  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                tgt = (r_cmd == CMD_NEXT) ? next_rd : prev_rd;
                if (f_live(tgt)) begin
                    word_re  = 1'b1;
                    word_ra  = tgt[AW-1:0];
                    n_cursor = tgt;
                    n_state  = S_WORD;
                end else begin
                    n_res_status = ST_NO_NODE;
                    n_state      = S_DONE;
                end
            end
            S_WORD: begin
                n_res_word = word_rd;
                n_res_has  = 1'b1;
                n_state    = S_DONE;
            end
            S_FREE: begin
                // unlink the taken node from the free list
                n_free = next_rd;
                if (r_ins) begin
                    next_re = 1'b1;
                    next_ra = r_aux[AW-1:0];
                    n_state = S_AFTER;
                end else begin
                    n_state = S_WR1;
                end
            end
            S_AFTER: begin
                n_after = next_rd;
                n_state = S_WR1;
            end
            S_WR1: begin
                word_we = 1'b1;
                word_wa = r_node[AW-1:0];
                word_wd = r_data;
                next_we = 1'b1;
                next_wa = r_node[AW-1:0];
                prev_we = 1'b1;
                prev_wa = r_node[AW-1:0];
                priority if (r_ins) begin
                    next_wd = r_after;
                    prev_wd = r_aux;
                    if (!f_live(r_after)) begin
                        n_tail = r_node;
                    end
                    n_state = S_WR2;
                end else if (r_cmd == CMD_PUSH_FRONT) begin
                    next_wd = r_aux;
                    prev_wd = NIL;
                    n_head  = r_node;
                    if (f_live(r_aux)) begin
                        n_state = S_WR2;
                    end else begin
                        n_tail  = r_node;
                        n_state = S_DONE;
                    end
                end else begin
                    // push back on an empty list: the only node
                    next_wd = NIL;
                    prev_wd = NIL;
                    n_head  = r_node;
                    n_tail  = r_node;
                    n_state = S_DONE;
                end
            end
            S_WR2: begin
                priority if (r_ins) begin
                    next_we = 1'b1;
                    next_wa = r_aux[AW-1:0];
                    next_wd = r_node;
                    prev_we = f_live(r_after);
                    prev_wa = r_after[AW-1:0];
                    prev_wd = r_node;
                end else if (r_cmd == CMD_PUSH_FRONT) begin
                    prev_we = 1'b1;
                    prev_wa = r_aux[AW-1:0];
                    prev_wd = r_node;
                end else begin
                    // pop: bridge the predecessor over the removed node
                    next_we = 1'b1;
                    next_wa = r_aux[AW-1:0];
                    next_wd = r_after;
                end
                n_state = S_DONE;
            end
            S_POP: begin
                n_res_word = word_rd;
                n_res_has  = 1'b1;
                n_aux      = prev_rd;
                n_after    = next_rd;
                if (!f_live(prev_rd)) begin
                    n_head = next_rd;
                end
                if (!f_live(next_rd)) begin
                    n_tail = prev_rd;
                end
                n_cursor = next_rd;
                n_free   = r_node;
                // return the node to the free list
                next_we  = 1'b1;
                next_wa  = r_node[AW-1:0];
                next_wd  = r_free;
                prev_we  = f_live(next_rd);
                prev_wa  = next_rd[AW-1:0];
                prev_wd  = prev_rd;
                n_state  = f_live(prev_rd) ? S_WR2 : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_cursor <= NIL;
            r_free   <= NIL;
            r_fresh  <= '0;
            r_ins    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cursor <= n_cursor;
            r_free   <= n_free;
            r_fresh  <= n_fresh;
            r_ins    <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_data       <= n_data;
        r_node       <= n_node;
        r_aux        <= n_aux;
        r_after      <= n_after;
        r_res_word   <= n_res_word;
        r_res_has    <= n_res_has;
        r_res_status <= n_res_status;
    end

    dll_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (word_we),
        .i_wr_addr (word_wa),
        .i_wr_data (word_wd),
        .i_rd_en   (word_re),
        .i_rd_addr (word_ra),
        .o_rd_data (word_rd)
    );

    dll_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_en   (next_re),
        .i_rd_addr (next_ra),
        .o_rd_data (next_rd)
    );

    dll_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_en   (prev_re),
        .i_rd_addr (prev_ra),
        .o_rd_data (prev_rd)
    );

    dll_out_stage #(.WORD_WIDTH(WORD_WIDTH)) u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_DONE),
        .i_word   (r_res_word),
        .i_has    (r_res_has),
        .i_status (r_res_status),
        .o_free   (out_free),
        .o_res    (o_res)
    );

    // head and tail are live together, and an empty list has no cursor
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (f_live(r_head) == f_live(r_tail)))
        else $error("head and tail disagree on an empty list");

    a_empty_no_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !f_live(r_head)) |-> !f_live(r_cursor))
        else $error("cursor live on an empty list");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_res.valid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL)
        else $error("fresh node count beyond pool size");
endmodule

>>> bench/tb_doubly_linked_list_with_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_with_cursor - regression bench for the linked list
// Drives command beats from a queue, predicts each result with its own copy of
// the list, pool and cursor, and checks every result beat in order under
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_with_cursor;
    import dll_pkg::*;

    localparam int NODES        = DEPTH_DEF;
    localparam int PTR_W        = $clog2(NODES + 1);
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic [WORD_WIDTH_DEF-1:0] word_t;
    typedef logic [PTR_W-1:0]          ptr_t;

    typedef struct packed {
        cmd_t  command;
        word_t data_in;
    } list_cmd_t;

    typedef struct packed {
        word_t               data_out;
        logic                has_data;
        logic [STATUS_W-1:0] status;
    } list_result_t;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_WALK, BURST_MIXED} burst_kind_t;

    localparam ptr_t NONE = ptr_t'(NODES);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dll_cmd_if #(.WORD_WIDTH(WORD_WIDTH_DEF)) cmd_ch ();
    dll_res_if #(.WORD_WIDTH(WORD_WIDTH_DEF)) res_ch ();

    doubly_linked_list_with_cursor #(
        .DEPTH      (NODES),
        .WORD_WIDTH (WORD_WIDTH_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Predicted list: node pool, links, ends, cursor and allocator.
    word_t slot_word [NODES];
    ptr_t  slot_fwd  [NODES];
    ptr_t  slot_back [NODES];
    ptr_t  list_head;
    ptr_t  list_tail;
    ptr_t  cursor_at;
    ptr_t  free_top;
    int    fresh_used;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];
    int           fail_count;
    int           stall_cycles;
    longint       cycle_no;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_node(ptr_t p);
        return p < NODES;
    endfunction

    function automatic void clear_list();
        list_head  = NONE;
        list_tail  = NONE;
        cursor_at  = NONE;
        free_top   = NONE;
        fresh_used = 0;
    endfunction

    // Reuse freed nodes first, then hand out never-used ones.
    function automatic ptr_t alloc_node();
        ptr_t n;
        n = NONE;
        if (is_node(free_top)) begin
            n = free_top;
            free_top = slot_fwd[n];
        end else if (fresh_used < NODES) begin
            n = ptr_t'(fresh_used);
            fresh_used++;
        end
        return n;
    endfunction

    function automatic logic [STATUS_W-1:0] link_after(ptr_t c, word_t d);
        ptr_t n;
        ptr_t succ;
        if (!is_node(c))
            return ST_NO_NODE;
        n = alloc_node();
        if (!is_node(n))
            return ST_FULL;
        succ = slot_fwd[c];
        slot_word[n] = d;
        slot_fwd[n]  = succ;
        slot_back[n] = c;
        if (is_node(succ))
            slot_back[succ] = n;
        else
            list_tail = n;
        slot_fwd[c] = n;
        return ST_OK;
    endfunction

    function automatic list_result_t seek(ptr_t target);
        list_result_t r;
        r = '0;
        if (is_node(target)) begin
            cursor_at  = target;
            r.data_out = slot_word[target];
            r.has_data = 1'b1;
        end else begin
            r.status = ST_NO_NODE;
        end
        return r;
    endfunction

    // Remove the cursor node and advance the cursor to its successor.
    function automatic list_result_t unlink_cursor();
        list_result_t r;
        ptr_t n;
        ptr_t pred;
        ptr_t succ;
        r = '0;
        if (!is_node(cursor_at)) begin
            r.status = ST_NO_NODE;
            return r;
        end
        n    = cursor_at;
        pred = slot_back[n];
        succ = slot_fwd[n];
        if (is_node(pred))
            slot_fwd[pred] = succ;
        else
            list_head = succ;
        if (is_node(succ))
            slot_back[succ] = pred;
        else
            list_tail = pred;
        r.data_out  = slot_word[n];
        r.has_data  = 1'b1;
        slot_fwd[n] = free_top;
        free_top    = n;
        cursor_at   = succ;
        return r;
    endfunction

    function automatic list_result_t apply_list_cmd(cmd_t op, word_t d);
        list_result_t r;
        ptr_t n;
        r = '0;
        case (op)
            CMD_FIRST: r = seek(list_head);
            CMD_NEXT:  r = seek(is_node(cursor_at) ? slot_fwd[cursor_at] : NONE);
            CMD_LAST:  r = seek(list_tail);
            CMD_PREV:  r = seek(is_node(cursor_at) ? slot_back[cursor_at] : NONE);
            CMD_PUSH_FRONT: begin
                n = alloc_node();
                if (!is_node(n)) begin
                    r.status = ST_FULL;
                end else begin
                    slot_word[n] = d;
                    slot_back[n] = NONE;
                    slot_fwd[n]  = list_head;
                    if (is_node(list_head))
                        slot_back[list_head] = n;
                    else
                        list_tail = n;
                    list_head = n;
                end
            end
            CMD_PUSH_BACK: begin
                // cursor lands on the old tail even if the push is dropped
                cursor_at = list_tail;
                if (is_node(list_tail)) begin
                    r.status = link_after(list_tail, d);
                end else begin
                    n = alloc_node();
                    if (!is_node(n)) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_word[n] = d;
                        slot_fwd[n]  = NONE;
                        slot_back[n] = NONE;
                        list_head    = n;
                        list_tail    = n;
                    end
                end
            end
            CMD_PUSH_AFTER: r.status = link_after(cursor_at, d);
            CMD_POP_FRONT: begin
                cursor_at = list_head;
                r = unlink_cursor();
            end
            CMD_POP_BACK: begin
                cursor_at = list_tail;
                r = unlink_cursor();
            end
            CMD_POP_CURSOR: r = unlink_cursor();
            CMD_CLEAR:      clear_list();
            default: ;
        endcase
        return r;
    endfunction

    function automatic void queue_cmd(cmd_t op, word_t d);
        list_cmd_t beat;
        beat.command = op;
        beat.data_in = d;
        pending_cmds.push_back(beat);
    endfunction

    // Long windows with no idling on either side.
    function automatic bit calm();
        return (cycle_no % 3000) < 800;
    endfunction

    always @(posedge i_clk) begin : drive_cmds
        list_cmd_t beat;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_results.push_back(apply_list_cmd(cmd_ch.command, cmd_ch.data_in));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_cmds.size() != 0 && (calm() || $urandom_range(0, 99) >= 20)) begin
                    beat = pending_cmds.pop_front();
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.command <= beat.command;
                    cmd_ch.data_in <= beat.data_in;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        list_result_t want;
        cycle_no <= cycle_no + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            res_ch.ready <= calm() || ($urandom_range(0, 99) >= 20);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command waiting: data_out %h", res_ch.data_out);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.data_out !== want.data_out) begin
                        $error("data_out: expected %h, got %h", want.data_out, res_ch.data_out);
                        fail_count++;
                    end
                    if (res_ch.has_data !== want.has_data) begin
                        $error("has_data: expected %b, got %b", want.has_data, res_ch.has_data);
                        fail_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("doubly_linked_list_with_cursor regression: fail");
        $finish;
    end

    initial begin : stimulus
        burst_kind_t kind;
        cmd_t        op;
        int          made;
        int          burst_len;
        int          roll;

        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.data_in = '0;
        res_ch.ready   = 1'b0;
        fail_count     = 0;
        stall_cycles   = 0;
        cycle_no       = 0;
        clear_list();

        // Empty list: every navigation, pop and push after the cursor finds nothing.
        queue_cmd(CMD_FIRST, 32'h0000_0001);
        queue_cmd(CMD_LAST, 32'h8000_0000);
        queue_cmd(CMD_NEXT, '0);
        queue_cmd(CMD_PREV, '1);
        queue_cmd(CMD_PUSH_AFTER, 32'h1234_5678);
        queue_cmd(CMD_POP_FRONT, '0);
        queue_cmd(CMD_POP_BACK, '0);
        queue_cmd(CMD_POP_CURSOR, '0);
        // Build a short list from both ends and after the cursor.
        queue_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        queue_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
        queue_cmd(CMD_PUSH_BACK, 32'hA5A5_A5A5);
        queue_cmd(CMD_PUSH_AFTER, 32'h5A5A_5A5A);
        queue_cmd(CMD_FIRST, '0);
        repeat (4) queue_cmd(CMD_NEXT, '0);
        queue_cmd(CMD_LAST, '0);
        queue_cmd(CMD_PREV, '0);
        queue_cmd(CMD_POP_CURSOR, '0);
        queue_cmd(CMD_POP_FRONT, '0);
        queue_cmd(CMD_POP_BACK, '0);
        queue_cmd(cmd_t'(11), 32'hDEAD_BEEF);
        queue_cmd(cmd_t'(15), '1);
        queue_cmd(CMD_CLEAR, '0);
        queue_cmd(CMD_FIRST, '0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            kind = (roll < 2) ? BURST_FILL : (roll < 4) ? BURST_DRAIN :
                   (roll < 7) ? BURST_WALK : BURST_MIXED;
            // fill bursts run long enough to overflow the pool
            burst_len = (kind == BURST_FILL) ? 80 : $urandom_range(20, 60);
            for (int k = 0; k < burst_len; k++) begin
                roll = $urandom_range(0, 99);
                case (kind)
                    BURST_FILL:
                        op = (roll < 40) ? CMD_PUSH_BACK : (roll < 70) ? CMD_PUSH_FRONT :
                             (roll < 92) ? CMD_PUSH_AFTER : CMD_PREV;
                    BURST_DRAIN:
                        op = (roll < 25) ? CMD_POP_FRONT : (roll < 50) ? CMD_POP_BACK :
                             (roll < 75) ? CMD_POP_CURSOR : (roll < 85) ? CMD_FIRST :
                             (roll < 95) ? CMD_NEXT : CMD_PUSH_BACK;
                    BURST_WALK:
                        op = (roll < 8)  ? CMD_FIRST : (roll < 16) ? CMD_LAST :
                             (roll < 40) ? CMD_NEXT : (roll < 64) ? CMD_PREV :
                             (roll < 78) ? CMD_POP_CURSOR : (roll < 92) ? CMD_PUSH_AFTER :
                             CMD_PUSH_FRONT;
                    default:
                        op = cmd_t'($urandom_range(0, 15));
                endcase
                queue_cmd(op, $urandom());
                made++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // hold a little longer to catch stray result beats
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("doubly_linked_list_with_cursor regression: pass");
        end else begin
            $display("doubly_linked_list_with_cursor regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
sv/dll_pkg.sv
sv/dll_ifs.sv
sv/dll_ram.sv
sv/dll_out_stage.sv
sv/doubly_linked_list_with_cursor.sv
bench/tb_doubly_linked_list_with_cursor.sv
